// ----- src/voxel_visible_face_finder_defines.svh -----
// assertion macros shared by the voxel face finder modules
// expects clk and rst_n in the scope of every use
`ifndef VOXEL_VISIBLE_FACE_FINDER_DEFINES_SVH
`define VOXEL_VISIBLE_FACE_FINDER_DEFINES_SVH
`ifndef SYNTHESIS
// checked outside reset
`define VVFF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);
// checked on every edge, reset included
`define VVFF_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) \
    else $error(msg);
`else
`define VVFF_ASSERT(label, prop, msg)
`define VVFF_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

// ----- src/vvff_pkg.sv -----
// shared types and constants for the voxel visible face finder
// no dependencies
package vvff_pkg;

  // default chunk edge length in voxels
  localparam int CHUNK_EDGE_DEF = 16;
  // vertices that one face adds to the running counter
  localparam logic [15:0] VERTS_PER_FACE = 16'd4;

  // face direction codes
  typedef logic [2:0] dir_t;
  localparam dir_t DIR_PX = 3'd0;
  localparam dir_t DIR_PY = 3'd1;
  localparam dir_t DIR_NX = 3'd2;
  localparam dir_t DIR_NY = 3'd3;
  localparam dir_t DIR_PZ = 3'd4;
  localparam dir_t DIR_NZ = 3'd5;

  // column read selects, in the order they are fetched
  typedef logic [2:0] rsel_t;
  localparam rsel_t RSEL_CENTER = 3'd0;
  localparam rsel_t RSEL_PX     = 3'd1;
  localparam rsel_t RSEL_PY     = 3'd2;
  localparam rsel_t RSEL_NX     = 3'd3;
  localparam rsel_t RSEL_NY     = 3'd4;
  // read step that only captures the last fetched column
  localparam rsel_t READ_LAST   = 3'd5;

  // controller to datapath commands
  typedef struct packed {
    logic  load;     // take the input item
    logic  clear;    // write zero at the clear address
    logic  wr_col;   // write the column mask of the held item
    logic  rd_en;    // read one column
    rsel_t rd_sel;
    logic  cap_en;   // capture the column read last cycle
    rsel_t cap_sel;
    logic  arm;      // load the face list from the captured bits
    logic  emit;     // move the next face into the output register
  } vvff_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic rem_any;   // query has at least one face
    logic rem_last;  // one face left in the list
    logic out_free;  // output register can take a face
  } vvff_sts_t;

endpackage

// ----- src/vvff_ram.sv -----
// generic single-port ram with registered read
// no dependencies
module vvff_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write or read one word per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

// ----- src/vvff_ctrl.sv -----
// controller of the voxel face finder: clear pass, column writes and reads, face emit
// depends on vvff_pkg and the shared assertion macros
`include "voxel_visible_face_finder_defines.svh"

module vvff_ctrl
  import vvff_pkg::*;
#(
  parameter int CHUNK_EDGE = CHUNK_EDGE_DEF,
  parameter int ADDR_W     = $clog2(CHUNK_EDGE * CHUNK_EDGE)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic [0:0]        in_tuser,
  output logic              in_tready,
  input  vvff_sts_t         sts,
  output vvff_cmd_t         cmd,
  output logic [ADDR_W-1:0] clr_addr
);

  localparam int DEPTH = CHUNK_EDGE * CHUNK_EDGE;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WRITE,
    ST_READ,
    ST_CHECK,
    ST_EMIT
  } state_t;

  state_t            state_r, state_nxt;
  rsel_t             step_r, step_nxt;
  logic [ADDR_W-1:0] clr_addr_r, clr_addr_nxt;
  logic              rdy_r, rdy_nxt;

  // next state and commands
  always_comb begin
    state_nxt    = state_r;
    step_nxt     = step_r;
    clr_addr_nxt = clr_addr_r;
    cmd          = '0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clear    = 1'b1;
        clr_addr_nxt = clr_addr_r + ADDR_W'(1);
        if (clr_addr_r == ADDR_W'(DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_tvalid && rdy_r) begin
          cmd.load  = 1'b1;
          step_nxt  = RSEL_CENTER;
          state_nxt = in_tuser[0] ? ST_READ : ST_WRITE;
        end
      end
      ST_WRITE: begin
        cmd.wr_col = 1'b1;
        state_nxt  = ST_IDLE;
      end
      ST_READ: begin
        // issue one column read and capture the one before it
        if (step_r != READ_LAST) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = step_r;
        end
        if (step_r != RSEL_CENTER) begin
          cmd.cap_en  = 1'b1;
          cmd.cap_sel = step_r - 3'd1;
        end
        step_nxt = step_r + 3'd1;
        if (step_r == READ_LAST) begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        cmd.arm   = 1'b1;
        state_nxt = sts.rem_any ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.rem_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    rdy_nxt = (state_nxt == ST_IDLE);
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      step_r     <= RSEL_CENTER;
      clr_addr_r <= '0;
      rdy_r      <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      step_r     <= step_nxt;
      clr_addr_r <= clr_addr_nxt;
      rdy_r      <= rdy_nxt;
    end
  end

  assign in_tready = rdy_r;
  assign clr_addr  = clr_addr_r;

  `VVFF_ASSERT(a_accept_leaves_idle, in_tvalid && rdy_r |=> !rdy_r, "ready after accept")
  `VVFF_ASSERT(a_step_range, state_r == ST_READ |-> step_r <= READ_LAST, "read step out of range")
  `VVFF_ASSERT(a_cap_after_rd, cmd.cap_en |-> $past(cmd.rd_en), "capture without read")

endmodule

// ----- src/vvff_datapath.sv -----
// datapath of the voxel face finder: column store, neighbor bits, face output
// depends on vvff_pkg, vvff_ram and the shared assertion macros
`include "voxel_visible_face_finder_defines.svh"

module vvff_datapath
  import vvff_pkg::*;
#(
  parameter int CHUNK_EDGE = CHUNK_EDGE_DEF,
  parameter int ADDR_W     = $clog2(CHUNK_EDGE * CHUNK_EDGE)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [23:0]       in_tdata,
  input  vvff_cmd_t         cmd,
  input  logic [ADDR_W-1:0] clr_addr,
  output vvff_sts_t         sts,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [31:0]       out_tdata,
  output logic              out_tlast
);

  localparam int DEPTH = CHUNK_EDGE * CHUNK_EDGE;

  // held item
  logic [3:0] x_r, y_r, z_r;
  logic [4:0] h_r;

  // column store port
  logic                  ram_we;
  logic [ADDR_W-1:0]     ram_addr;
  logic [CHUNK_EDGE-1:0] ram_wdata, ram_rdata;

  // neighbor coordinates of the selected column
  rsel_t      csel;
  logic [4:0] nx, ny;
  logic       oob;
  logic [15:0] lin;
  logic       rd_oob_r;

  // captured bits
  logic       center_solid_r;
  logic [5:0] vis_r;
  logic [5:0] rem_r;

  // face selection
  dir_t       dir_sel;
  logic [5:0] pick;
  logic [5:0] rem_after;

  // output register and vertex counter
  logic        out_valid_r;
  logic [3:0]  fx_r, fy_r, fz_r;
  dir_t        fdir_r;
  logic [15:0] fv_r;
  logic        flast_r;
  logic [15:0] vcnt_r;

  function automatic logic col_bit(input logic [CHUNK_EDGE-1:0] w, input logic [5:0] k);
    logic [CHUNK_EDGE-1:0] s;
    s = w >> k;
    return s[0];
  endfunction

  // item register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_r <= in_tdata[3:0];
      y_r <= in_tdata[7:4];
      z_r <= in_tdata[11:8];
      h_r <= in_tdata[16:12];
    end
  end

  // coordinates of the column to access
  always_comb begin
    csel = cmd.rd_en ? cmd.rd_sel : RSEL_CENTER;
    nx   = {1'b0, x_r};
    ny   = {1'b0, y_r};
    oob  = 1'b0;
    case (csel)
      RSEL_PX: nx = {1'b0, x_r} + 5'd1;
      RSEL_PY: ny = {1'b0, y_r} + 5'd1;
      RSEL_NX: begin
        nx  = {1'b0, x_r} - 5'd1;
        oob = (x_r == 4'd0);
      end
      RSEL_NY: begin
        ny  = {1'b0, y_r} - 5'd1;
        oob = (y_r == 4'd0);
      end
      default: ;
    endcase
    if (int'(nx) >= CHUNK_EDGE || int'(ny) >= CHUNK_EDGE) begin
      oob = 1'b1;
    end
    lin = 16'(ny) * 16'(CHUNK_EDGE) + 16'(nx);
  end

  // store port: clear pass, column write, or column read
  always_comb begin
    ram_addr  = cmd.clear ? clr_addr : ADDR_W'(lin);
    ram_we    = cmd.clear || (cmd.wr_col && !oob);
    ram_wdata = cmd.clear ? '0 : ~({CHUNK_EDGE{1'b1}} << h_r);
  end

  vvff_ram #(
    .WIDTH (CHUNK_EDGE),
    .DEPTH (DEPTH)
  ) u_col_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // capture neighbor bits as the reads return
  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_oob_r <= oob;
    end
    if (cmd.cap_en) begin
      case (cmd.cap_sel)
        RSEL_CENTER: begin
          // the voxel itself must lie inside the chunk
          center_solid_r <= !rd_oob_r && (int'(z_r) < CHUNK_EDGE) &&
                            col_bit(ram_rdata, {2'b00, z_r});
          vis_r[DIR_PZ]  <= !col_bit(ram_rdata, {2'b00, z_r} + 6'd1);
          vis_r[DIR_NZ]  <= (z_r == 4'd0) || !col_bit(ram_rdata, {2'b00, z_r} - 6'd1);
        end
        RSEL_PX: vis_r[DIR_PX] <= rd_oob_r || !col_bit(ram_rdata, {2'b00, z_r});
        RSEL_PY: vis_r[DIR_PY] <= rd_oob_r || !col_bit(ram_rdata, {2'b00, z_r});
        RSEL_NX: vis_r[DIR_NX] <= rd_oob_r || !col_bit(ram_rdata, {2'b00, z_r});
        RSEL_NY: vis_r[DIR_NY] <= rd_oob_r || !col_bit(ram_rdata, {2'b00, z_r});
        default: ;
      endcase
    end
  end

  // lowest pending face direction
  always_comb begin
    dir_sel = DIR_PX;
    for (int i = 5; i >= 0; i--) begin
      if (rem_r[i]) begin
        dir_sel = 3'(i);
      end
    end
    pick      = 6'd1 << dir_sel;
    rem_after = rem_r & ~pick;
  end

  // face list, output register and vertex counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r       <= '0;
      out_valid_r <= 1'b0;
      vcnt_r      <= '0;
    end else begin
      if (cmd.arm) begin
        rem_r <= center_solid_r ? vis_r : 6'd0;
      end else if (cmd.emit) begin
        rem_r <= rem_after;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
        vcnt_r      <= vcnt_r + VERTS_PER_FACE;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      fx_r    <= x_r;
      fy_r    <= y_r;
      fz_r    <= z_r;
      fdir_r  <= dir_sel;
      fv_r    <= vcnt_r;
      flast_r <= (rem_after == 6'd0);
    end
  end

  assign sts.rem_any  = center_solid_r && (vis_r != 6'd0);
  assign sts.rem_last = ((rem_r & (rem_r - 6'd1)) == 6'd0);
  assign sts.out_free = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, fv_r, fdir_r, fz_r, fy_r, fx_r};
  assign out_tlast  = flast_r;

  `VVFF_ASSERT(a_emit_has_face, cmd.emit |-> rem_r != 6'd0, "emit with empty face list")
  `VVFF_ASSERT(a_vcnt_step, cmd.emit |=> vcnt_r == $past(vcnt_r) + VERTS_PER_FACE, "vertex step")
  `VVFF_ASSERT_ALWAYS(a_rst_out, !rst_n |=> !out_tvalid, "output valid after reset")

endmodule

// ----- src/voxel_visible_face_finder.sv -----
// column write: the column is written in ST_WRITE, then ready again; no item out
// face query: five single-port column ram reads set the pace; the first face is
// moved into the output register in ST_EMIT after the reads and ST_CHECK, then one
// face per cycle while the output register can take it
// after reset a clearing pass zeroes the column ram with in_tready low; the vertex
// counter resets to zero
module voxel_visible_face_finder
  import vvff_pkg::*;
#(
  parameter int CHUNK_EDGE = CHUNK_EDGE_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // pos_x, pos_y, pos_z, column_height, zero fill
  input  logic [0:0]  in_tuser,   // req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // face_x, face_y, face_z, face_dir, first_vertex, zero fill
  output logic        out_tlast   // last_face
);

  localparam int ADDR_W = $clog2(CHUNK_EDGE * CHUNK_EDGE);

  vvff_cmd_t         cmd;
  vvff_sts_t         sts;
  logic [ADDR_W-1:0] clr_addr;

  // sequencer
  vvff_ctrl #(
    .CHUNK_EDGE (CHUNK_EDGE),
    .ADDR_W     (ADDR_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tuser  (in_tuser),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd),
    .clr_addr  (clr_addr)
  );

  // column store and face logic
  vvff_datapath #(
    .CHUNK_EDGE (CHUNK_EDGE),
    .ADDR_W     (ADDR_W)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .clr_addr   (clr_addr),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

// ----- sim/voxel_visible_face_finder_tb.sv -----
// self-checking testbench for voxel_visible_face_finder: stream stimulus, face prediction
// depends on vvff_pkg and the voxel_visible_face_finder rtl, nothing else
`timescale 1ns / 100ps

module voxel_visible_face_finder_tb;
  import vvff_pkg::*;

  localparam int EDGE = CHUNK_EDGE_DEF;
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;
  // row flag: faces come from the predictor, not typed in
  localparam int PREDICT = -1;
  localparam int N_DIRECTED = 27;
  // lone voxel queries, six faces each
  localparam int LONE_QUERIES = 20;
  localparam int N_RANDOM = 180;
  localparam int LONG_HOLD = 300;
  localparam int HOLD_AT = N_DIRECTED + 1 + LONE_QUERIES + 40;
  localparam longint TIMEOUT_NS = 64'd1_000_000;

  typedef struct {
    logic       rq;
    logic [3:0] x;
    logic [3:0] y;
    logic [3:0] z;
    logic [4:0] h;
    int         faces;  // face mask indexed by direction code, or PREDICT
  } stim_row_t;

  typedef struct {
    logic [3:0]  x;
    logic [3:0]  y;
    logic [3:0]  z;
    dir_t        dir;
    logic [15:0] vtx;
    logic        is_last;
  } face_t;

  typedef enum int {RX_STEADY, RX_COIN, RX_SPARSE, RX_MOSTLY} rx_mode_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;   // pos_x, pos_y, pos_z, column_height, zero fill
  logic [0:0]  in_tuser;   // req_type
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;  // face_x, face_y, face_z, face_dir, first_vertex, zero fill
  logic        out_tlast;  // last_face

  // predicted chunk contents and vertex counter
  logic [15:0] solid_cols [EDGE][EDGE];
  logic [15:0] next_vertex;
  face_t       pending_faces [$];
  int          err_count;
  int          items_in;
  int          burst_left;

  const dir_t face_order [6] = '{DIR_PX, DIR_PY, DIR_NX, DIR_NY, DIR_PZ, DIR_NZ};

  // directed rows; masks: bit n set means a face with direction code n
  stim_row_t directed_rows [N_DIRECTED] = '{
    '{REQ_QUERY, 4'd0,  4'd0,  4'd0,  5'd0,  0},        // empty chunk after reset
    '{REQ_QUERY, 4'd15, 4'd15, 4'd15, 5'd0,  0},
    '{REQ_WRITE, 4'd0,  4'd0,  4'd0,  5'd1,  PREDICT},
    '{REQ_QUERY, 4'd0,  4'd0,  4'd0,  5'd0,  'h3F},     // lone corner voxel
    '{REQ_QUERY, 4'd0,  4'd0,  4'd1,  5'd0,  0},        // empty above it
    '{REQ_WRITE, 4'd15, 4'd15, 4'd0,  5'd31, PREDICT},  // height saturates
    '{REQ_QUERY, 4'd15, 4'd15, 4'd15, 5'd0,  'h1F},     // top of full column
    '{REQ_QUERY, 4'd15, 4'd15, 4'd0,  5'd0,  'h2F},     // bottom of full column
    '{REQ_WRITE, 4'd15, 4'd15, 4'd0,  5'd16, PREDICT},
    '{REQ_WRITE, 4'd1,  4'd0,  4'd0,  5'd17, PREDICT},
    '{REQ_QUERY, 4'd0,  4'd0,  4'd0,  5'd0,  'h3E},     // +x neighbor now solid
    '{REQ_WRITE, 4'd0,  4'd1,  4'd0,  5'd8,  PREDICT},
    '{REQ_QUERY, 4'd0,  4'd0,  4'd0,  5'd0,  PREDICT},
    '{REQ_WRITE, 4'd1,  4'd1,  4'd0,  5'd2,  PREDICT},
    '{REQ_WRITE, 4'd0,  4'd0,  4'd0,  5'd4,  PREDICT},
    '{REQ_QUERY, 4'd0,  4'd0,  4'd1,  5'd0,  PREDICT},
    '{REQ_QUERY, 4'd0,  4'd0,  4'd3,  5'd0,  PREDICT},
    '{REQ_WRITE, 4'd0,  4'd0,  4'd0,  5'd0,  PREDICT},  // clear a column
    '{REQ_QUERY, 4'd0,  4'd0,  4'd0,  5'd0,  0},
    '{REQ_WRITE, 4'd7,  4'd8,  4'd0,  5'd16, PREDICT},
    '{REQ_WRITE, 4'd8,  4'd8,  4'd0,  5'd16, PREDICT},
    '{REQ_WRITE, 4'd6,  4'd8,  4'd0,  5'd16, PREDICT},
    '{REQ_WRITE, 4'd7,  4'd7,  4'd0,  5'd16, PREDICT},
    '{REQ_WRITE, 4'd7,  4'd9,  4'd0,  5'd16, PREDICT},
    '{REQ_QUERY, 4'd7,  4'd8,  4'd5,  5'd0,  0},        // buried solid voxel
    '{REQ_QUERY, 4'd7,  4'd8,  4'd15, 5'd0,  'h10},
    '{REQ_QUERY, 4'd7,  4'd8,  4'd0,  5'd0,  'h20}
  };

  voxel_visible_face_finder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // 12 ns clock
  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // outside the chunk counts as empty
  function automatic logic is_solid(int x, int y, int z);
    if (x < 0 || y < 0 || z < 0 || x >= EDGE || y >= EDGE || z >= EDGE) return 1'b0;
    return solid_cols[x][y][z];
  endfunction

  function automatic logic [5:0] visible_mask(int x, int y, int z);
    logic [5:0] mask;
    int nx, ny, nz;
    mask = '0;
    if (!is_solid(x, y, z)) return mask;
    foreach (face_order[i]) begin
      nx = x;
      ny = y;
      nz = z;
      case (face_order[i])
        DIR_PX: nx = x + 1;
        DIR_PY: ny = y + 1;
        DIR_NX: nx = x - 1;
        DIR_NY: ny = y - 1;
        DIR_PZ: nz = z + 1;
        default: nz = z - 1;
      endcase
      mask[face_order[i]] = !is_solid(nx, ny, nz);
    end
    return mask;
  endfunction

  // one expected face per mask bit, in direction order, counter advancing
  function automatic void queue_faces(logic [3:0] x, logic [3:0] y, logic [3:0] z,
                                      logic [5:0] mask);
    face_t f;
    foreach (face_order[i]) begin
      if (mask[face_order[i]]) begin
        f.x = x;
        f.y = y;
        f.z = z;
        f.dir = face_order[i];
        f.vtx = next_vertex;
        f.is_last = (mask >> (face_order[i] + 1)) == '0;
        pending_faces.push_back(f);
        next_vertex = next_vertex + VERTS_PER_FACE;
      end
    end
  endfunction

  // update the chunk on a write, queue the visible faces on a query
  function automatic void track_request(logic rq, logic [3:0] x, logic [3:0] y,
                                        logic [3:0] z, logic [4:0] h);
    if (rq == REQ_WRITE) begin
      if (x < EDGE && y < EDGE)
        solid_cols[x][y] = (h >= EDGE) ? '1 : (16'(1) << h) - 16'(1);
    end else begin
      queue_faces(x, y, z, visible_mask(x, y, z));
    end
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_count++;
    end
  endfunction

  // sender pacing: bursts of random length, random gaps between them
  task automatic pace_sender();
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
      end
    end
    burst_left--;
  endtask

  // present one item and hold it until accepted; valid stays up afterwards
  task automatic offer_item(logic rq, logic [3:0] x, logic [3:0] y, logic [3:0] z,
                            logic [4:0] h);
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser <= rq;
    in_tdata <= {7'd0, h, z, y, x};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_in++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_faces.size() != 0) @(negedge clk);
  endtask

  // coordinates clustered in small patches half the time so neighbors are solid
  function automatic logic [3:0] pick_coord();
    if ($urandom_range(0, 1) == 0) return 4'($urandom_range(0, 15));
    return 4'($urandom_range(0, 3) + 6 * $urandom_range(0, 2));
  endfunction

  // receiver: stall pattern in runs, plus one long hold-off
  initial begin : receiver
    rx_mode_t rx_mode;
    int run_left;
    int hold_left;
    logic held;
    out_tready = 1'b0;
    run_left = 0;
    hold_left = 0;
    held = 1'b0;
    rx_mode = RX_STEADY;
    forever begin
      @(negedge clk);
      if (!held && items_in >= HOLD_AT) begin
        held = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        if (run_left == 0) begin
          rx_mode = rx_mode_t'($urandom_range(0, 3));
          run_left = $urandom_range(5, 40);
        end
        run_left--;
        case (rx_mode)
          RX_STEADY: out_tready <= 1'b1;
          RX_COIN:   out_tready <= 1'($urandom_range(0, 1));
          RX_SPARSE: out_tready <= ($urandom_range(0, 3) == 0);
          default:   out_tready <= ($urandom_range(0, 4) != 0);
        endcase
      end
    end
  end

  // compare every accepted face item with the oldest expectation
  always @(posedge clk) begin : face_monitor
    face_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_faces.size() == 0) begin
        $error("face item with none expected: data %h last %b", out_tdata, out_tlast);
        err_count++;
      end else begin
        want = pending_faces.pop_front();
        check_field("face_x", want.x, out_tdata[3:0]);
        check_field("face_y", want.y, out_tdata[7:4]);
        check_field("face_z", want.z, out_tdata[11:8]);
        check_field("face_dir", want.dir, out_tdata[14:12]);
        check_field("first_vertex", want.vtx, out_tdata[30:15]);
        check_field("last_face", want.is_last, out_tlast);
      end
    end
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : stimulus
    logic       rq;
    logic [3:0] x, y, z;
    logic [4:0] h;
    int         nsolid;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    err_count = 0;
    items_in = 0;
    burst_left = 0;
    next_vertex = '0;
    foreach (solid_cols[i, j]) solid_cols[i][j] = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed rows; the clearing pass just shows up as a long in_tready low
    foreach (directed_rows[i]) begin
      pace_sender();
      offer_item(directed_rows[i].rq, directed_rows[i].x, directed_rows[i].y,
                 directed_rows[i].z, directed_rows[i].h);
      if (directed_rows[i].faces == PREDICT)
        track_request(directed_rows[i].rq, directed_rows[i].x, directed_rows[i].y,
                      directed_rows[i].z, directed_rows[i].h);
      else
        queue_faces(directed_rows[i].x, directed_rows[i].y, directed_rows[i].z,
                    6'(directed_rows[i].faces));
    end

    // isolated voxel queried back to back, six faces each
    pace_sender();
    offer_item(REQ_WRITE, 4'd3, 4'd12, 4'd0, 5'd1);
    track_request(REQ_WRITE, 4'd3, 4'd12, 4'd0, 5'd1);
    for (int n = 0; n < LONE_QUERIES; n++) begin
      pace_sender();
      h = 5'($urandom_range(0, 31));
      offer_item(REQ_QUERY, 4'd3, 4'd12, 4'd0, h);
      track_request(REQ_QUERY, 4'd3, 4'd12, 4'd0, h);
    end

    // random writes and queries, mostly aimed at solid voxels
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == N_RANDOM / 2) wait_drained();
      pace_sender();
      x = pick_coord();
      y = pick_coord();
      if ($urandom_range(0, 99) < 35) begin
        rq = REQ_WRITE;
        z = 4'($urandom_range(0, 15));
        h = ($urandom_range(0, 5) == 0) ? 5'($urandom_range(17, 31)) : 5'($urandom_range(0, 16));
      end else begin
        rq = REQ_QUERY;
        nsolid = $countones(solid_cols[x][y]);
        if (nsolid > 0 && $urandom_range(0, 9) < 8)
          z = 4'($urandom_range(0, nsolid - 1));
        else
          z = 4'($urandom_range(0, 15));
        h = 5'($urandom_range(0, 31));
      end
      offer_item(rq, x, y, z, h);
      track_request(rq, x, y, z, h);
    end

    // drain, then keep watching the output to catch stray faces
    wait_drained();
    repeat (32) @(negedge clk);
    if (err_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
